@@ rtl/epdm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epdm_pkg: shared constants for the echo pulse distance meter
// Field widths, register indexes, reset values and conversion constants.
// ----------------------------------------------------------------------------
package epdm_pkg;

  localparam int unsigned TRIG_CNT_W        = 4;
  localparam int unsigned TRIGGER_TICKS_DEF = 10;
  localparam int unsigned TIMEOUT_W         = 16;
  localparam int unsigned WIDTH_W           = 16;
  localparam int unsigned DIST_W            = 9;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNIT    = 1'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30000;

  // width/58 = (width>>1)/29, width/148 = (width>>2)/37, each done as a
  // multiply by ceil(2^20/d); exact over the shifted 16-bit range
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned QUOT_W      = 12;
  localparam logic [RECIP_W-1:0] RECIP_CM = 16'd36158;
  localparam logic [RECIP_W-1:0] RECIP_IN = 16'd28340;

  localparam logic [DIST_W-1:0] DIST_MAX_CM = 9'd400;
  localparam logic [DIST_W-1:0] DIST_MAX_IN = 9'd157;

endpackage

@@ rtl/epdm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epdm_in_if / epdm_out_if: tick and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface epdm_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink   (input valid, input start_req, input echo, output ready);
endinterface

interface epdm_out_if;
  import epdm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 trigger;
  logic                 done_res;
  logic                 timed_out;
  logic [WIDTH_W-1:0]   pulse_width;
  logic [DIST_W-1:0]    distance;

  modport source (output valid, output trigger, output done_res, output timed_out,
                  output pulse_width, output distance, input ready);
  modport sink   (input valid, input trigger, input done_res, input timed_out,
                  input pulse_width, input distance, output ready);
endinterface

@@ rtl/epdm_dist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epdm_dist: pulse width to distance
// Constant divide by reciprocal multiply, then clamp to the unit's range.
// ----------------------------------------------------------------------------
module epdm_dist (
  input  logic [epdm_pkg::WIDTH_W-1:0] width,
  input  logic                         unit_inch,
  output logic [epdm_pkg::DIST_W-1:0]  distance
);
  import epdm_pkg::*;

  logic [WIDTH_W-1:0]           x;
  logic [RECIP_W-1:0]           m;
  logic [WIDTH_W+RECIP_W-1:0]   prod;
  logic [QUOT_W-1:0]            quot;
  logic [DIST_W-1:0]            lim;

  always_comb begin
    if (unit_inch) begin
      x   = width >> 2;
      m   = RECIP_IN;
      lim = DIST_MAX_IN;
    end else begin
      x   = width >> 1;
      m   = RECIP_CM;
      lim = DIST_MAX_CM;
    end
    prod = (WIDTH_W+RECIP_W)'(x) * (WIDTH_W+RECIP_W)'(m);
    quot = prod[RECIP_SHIFT +: QUOT_W];
    if (quot > QUOT_W'(lim)) begin
      distance = lim;
    end else begin
      distance = quot[DIST_W-1:0];
    end
  end

endmodule

@@ rtl/echo_pulse_distance_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_pulse_distance_meter: ultrasonic echo pulse width distance meter
// Counts echo high time per 1 us tick and converts it to cm or inches.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per 1 us tick: start_req and the sampled echo.
//   out_ch returns exactly one beat per input beat: the trigger level for
//   that tick, and on the finishing tick done_res with pulse width and
//   distance (or timed_out with zeros).
//   cfg_we/cfg_index/cfg_wdata write timeout_ticks (index 0) and unit_inch
//   (index 1); write only while the block is idle.
//   The result beat is registered; ticks flow at one per cycle while the
//   receiver takes each result. The whole step, the reciprocal multiply of
//   the distance conversion included, sits between the input handshake and
//   the result register.
//   in_ch.ready stays high while the result register is empty or being
//   taken; a stalled receiver holds the result and stops ticks behind it.
//   Reset (rst_n low, synchronous) returns to idle with timeout 30000 and
//   centimetres, and empties the result register.
// ----------------------------------------------------------------------------
module echo_pulse_distance_meter #(
  parameter int unsigned TRIGGER_TICKS = epdm_pkg::TRIGGER_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  epdm_in_if.sink                         in_ch,
  epdm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [epdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [epdm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import epdm_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2
  } phase_t;

  // configuration
  logic [TIMEOUT_W-1:0]  timeout_r;
  logic                  unit_inch_r;

  // measurement state
  phase_t                phase_r, phase_nxt, ph_cur;
  logic                  echo_before_r;
  logic [TRIG_CNT_W-1:0] trig_cnt_r, trig_cnt_nxt, trig_cnt_cur;
  logic [TIMEOUT_W-1:0]  wait_r, wait_nxt, wait_cur, wait_inc;
  logic [WIDTH_W-1:0]    width_r, width_nxt, width_cur;

  // result register
  logic                  out_valid_r;
  logic                  trigger_r;
  logic                  done_r;
  logic                  timed_out_r;
  logic [WIDTH_W-1:0]    pw_r;
  logic [DIST_W-1:0]     dist_r;

  logic                  in_acc;
  logic                  rise, fall, trig;
  logic                  done, tmo, fin;
  logic [DIST_W-1:0]     dist_cv;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign rise = in_ch.echo && !echo_before_r;
  assign fall = !in_ch.echo && echo_before_r;

  always_comb begin
    ph_cur       = phase_r;
    trig_cnt_cur = trig_cnt_r;
    wait_cur     = wait_r;
    width_cur    = width_r;
    if (phase_r != PH_RISE && phase_r != PH_FALL) begin
      ph_cur = PH_IDLE;
      if (in_ch.start_req) begin
        ph_cur       = PH_RISE;
        trig_cnt_cur = TRIG_CNT_W'(TRIGGER_TICKS);
        wait_cur     = '0;
        width_cur    = '0;
      end
    end

    trig      = (trig_cnt_cur != '0);
    wait_inc  = wait_cur + 1'b1;
    phase_nxt = ph_cur;
    wait_nxt  = wait_cur;
    width_nxt = width_cur;
    done      = 1'b0;
    tmo       = 1'b0;
    fin       = 1'b0;

    case (ph_cur)
      PH_RISE: begin
        if (rise) begin
          phase_nxt = PH_FALL;
          width_nxt = WIDTH_W'(1);
          wait_nxt  = '0;
        end else if (!trig) begin
          wait_nxt = wait_inc;
          if (wait_inc >= timeout_r) begin
            done = 1'b1;
            tmo  = 1'b1;
          end
        end
      end
      PH_FALL: begin
        // falling edges under the trigger are not armed yet
        if (trig) begin
          width_nxt = rise ? WIDTH_W'(1) : width_cur + 1'b1;
        end else if (fall) begin
          done = 1'b1;
          fin  = 1'b1;
        end else begin
          width_nxt = width_cur + 1'b1;
          wait_nxt  = wait_inc;
          if (wait_inc >= timeout_r) begin
            done = 1'b1;
            tmo  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (done) begin
      phase_nxt = PH_IDLE;
      wait_nxt  = '0;
    end
    trig_cnt_nxt = trig ? trig_cnt_cur - 1'b1 : trig_cnt_cur;
  end

  epdm_dist u_dist (
    .width     (width_cur),
    .unit_inch (unit_inch_r),
    .distance  (dist_cv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RESET;
      unit_inch_r   <= 1'b0;
      phase_r       <= PH_IDLE;
      echo_before_r <= 1'b0;
      trig_cnt_r    <= '0;
      wait_r        <= '0;
      width_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_TIMEOUT) begin
          timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        end else if (cfg_index == CFG_IDX_UNIT) begin
          unit_inch_r <= cfg_wdata[0];
        end
      end
      if (in_acc) begin
        phase_r       <= phase_nxt;
        echo_before_r <= in_ch.echo;
        trig_cnt_r    <= trig_cnt_nxt;
        wait_r        <= wait_nxt;
        width_r       <= width_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      trigger_r   <= trig;
      done_r      <= done;
      timed_out_r <= tmo;
      pw_r        <= fin ? width_cur : '0;
      dist_r      <= fin ? dist_cv : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.trigger     = trigger_r;
  assign out_ch.done_res    = done_r;
  assign out_ch.timed_out   = timed_out_r;
  assign out_ch.pulse_width = pw_r;
  assign out_ch.distance    = dist_r;

  // a timeout beat carries no measurement
  a_tmo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && timed_out_r |-> done_r && pw_r == '0 && dist_r == '0)
    else $error("timeout beat with nonzero width or distance");

  // completion is only possible once the trigger has ended
  a_trig_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && trigger_r |-> !done_r)
    else $error("done while trigger high");

  // a start taken while idle leaves idle
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_IDLE && in_ch.start_req |=> phase_r != PH_IDLE)
    else $error("start accepted but phase stayed idle");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> dist_r <= DIST_MAX_CM)
    else $error("distance beyond clamp");

  // an empty result register never blocks ticks
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule
